@@ src/xor_sprite_row_blitter_defines.svh @@
// Assertion macros used by the checker file of the sprite row blitter.
`ifndef XOR_SPRITE_ROW_BLITTER_DEFINES_SVH
`define XOR_SPRITE_ROW_BLITTER_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define XSRB_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Same, on the block clock and reset.
`define XSRB_ASSERT_CLK(label, prop, msg) `XSRB_ASSERT(label, clk, rst_n, prop, msg)

`endif

@@ src/xsrb_pkg.sv @@
// Types and constants shared by the sprite row blitter modules.
package xsrb_pkg;

    localparam int ADDRESS_BITS = 24;
    localparam int CLIP_W       = 10;
    localparam int STRIDE_W     = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 3;
    localparam int POS_W        = 11;
    localparam int SIZE_W       = 6;
    localparam int ROW_HALF_W   = 64;
    localparam int ROW_W        = 2 * ROW_HALF_W;
    localparam int BYTE_CNT_W   = 5;
    localparam int BYTE_OFS_W   = 4;
    localparam int NIB_IDX_W    = 5;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    localparam logic [CLIP_W-1:0]   CLIP_LEFT_RST   = 10'd0;
    localparam logic [CLIP_W-1:0]   CLIP_RIGHT_RST  = 10'd319;
    localparam logic [CLIP_W-1:0]   CLIP_TOP_RST    = 10'd0;
    localparam logic [CLIP_W-1:0]   CLIP_BOTTOM_RST = 10'd239;
    localparam logic [STRIDE_W-1:0] STRIDE_RST      = 11'd320;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_RIGHT  = 3'd1,
        CFG_CLIP_TOP    = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_LINE_STRIDE = 3'd4
    } xsrb_cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FLUSH
    } xsrb_state_t;

    typedef struct packed {
        logic sprite_load;
        logic row_count;
        logic row_load;
        logic step;
        logic flush;
    } xsrb_cmd_t;

    typedef struct packed {
        logic row_drawn;
        logic last_pos;
        logic nib_nz;
        logic held_valid;
        logic out_free;
    } xsrb_status_t;

endpackage

@@ src/xsrb_ctrl.sv @@
// Controller state machine: input acceptance and nibble walk sequencing.
module xsrb_ctrl
    import xsrb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         command,
    input  xsrb_status_t status,
    output logic         in_stall,
    output xsrb_cmd_t    cmd
);

    xsrb_state_t state_reg;
    xsrb_state_t state_next;
    logic        can_step;

    // Hold the walk when a new nibble would displace a held result into a full slot
    assign can_step = !(status.nib_nz && status.held_valid && !status.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && command == CMD_ROW && status.row_drawn)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_step && status.last_pos)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = 1'b1;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.sprite_load = in_valid && command == CMD_START;
                cmd.row_count   = in_valid && command == CMD_ROW;
                cmd.row_load    = in_valid && command == CMD_ROW && status.row_drawn;
            end
            ST_EMIT:
            begin
                cmd.step = can_step;
            end
            ST_FLUSH:
            begin
                cmd.flush = status.held_valid && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ src/xsrb_datapath.sv @@
// Datapath: clip registers, sprite clipping, row address and nibble walk, output register.
module xsrb_datapath
    import xsrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [SIZE_W-1:0]        width_pixels,
    input  logic [SIZE_W-1:0]        height_rows,
    input  logic [1:0]               flip_bits,
    input  logic [ADDRESS_BITS-1:0]  display_base,
    input  logic [ROW_HALF_W-1:0]    row_bytes_low,
    input  logic [ROW_HALF_W-1:0]    row_bytes_high,
    input  logic                     out_stall,
    input  xsrb_cmd_t                cmd,
    output xsrb_status_t             status,
    output logic                     out_valid,
    output logic [ADDRESS_BITS-1:0]  write_address,
    output logic [7:0]               xor_mask,
    output logic                     last_of_row
);

    localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_HEIGHT);

    // Configuration
    logic [CLIP_W-1:0]   clip_left_reg, clip_left_next;
    logic [CLIP_W-1:0]   clip_right_reg, clip_right_next;
    logic [CLIP_W-1:0]   clip_top_reg, clip_top_next;
    logic [CLIP_W-1:0]   clip_bottom_reg, clip_bottom_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;

    // Sprite state
    logic [ADDRESS_BITS-1:0] first_addr_reg, first_addr_next;
    logic [BYTE_OFS_W-1:0]   ofs_reg, ofs_next;
    logic [BYTE_CNT_W-1:0]   vis_reg, vis_next;
    logic [POS_W-1:0]        top_reg, top_next;
    logic [SIZE_W-1:0]       height_reg, height_next;
    logic [SIZE_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [1:0]              flip_reg, flip_next;
    logic                    fully_reg, fully_next;

    // Row walk
    logic [ROW_W-1:0]        row_bits_reg, row_bits_next;
    logic [ADDRESS_BITS-1:0] cur_addr_reg, cur_addr_next;
    logic [NIB_IDX_W-1:0]    nib_idx_reg, nib_idx_next;
    logic [NIB_IDX_W-1:0]    remain_reg, remain_next;
    logic                    held_valid_reg, held_valid_next;
    logic [ADDRESS_BITS-1:0] held_addr_reg, held_addr_next;
    logic [3:0]              held_nib_reg, held_nib_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [ADDRESS_BITS-1:0] out_addr_reg, out_addr_next;
    logic [3:0]              out_nib_reg, out_nib_next;
    logic                    out_last_reg, out_last_next;

    // Start command clipping
    logic [SIZE_W-1:0]       w_sat, h_sat;
    logic signed [12:0]      x_s, w_s, left_s, right_s, excess_s, lgap_s;
    logic                    reject, hflip_in;
    logic [BYTE_CNT_W-1:0]   cnt_half, cnt_r, cnt_l, ofs_r;
    logic [9:0]              trim_r;
    logic [10:0]             adj;
    logic [BYTE_OFS_W-1:0]   ofs_l;
    logic [ADDRESS_BITS-1:0] base_adj;

    // Row checks
    logic [SIZE_W-1:0]       yrow;
    logic signed [12:0]      ypix_s;
    logic                    row_live, in_range;
    logic [16:0]             row_offset;
    logic [ADDRESS_BITS-1:0] row_addr;
    logic [NIB_IDX_W-1:0]    nib_unit;
    logic [3:0]              cur_nib;
    logic                    out_free, push_mid;

    // ---------------- clipping at the start command ----------------
    always_comb
    begin
        w_sat    = (width_pixels > MAX_W) ? MAX_W : width_pixels;
        h_sat    = (height_rows > MAX_H) ? MAX_H : height_rows;
        hflip_in = flip_bits[0];
        x_s      = $signed({{2{pos_x[POS_W-1]}}, pos_x});
        w_s      = $signed({7'b0, w_sat});
        left_s   = $signed({3'b0, clip_left_reg});
        right_s  = $signed({3'b0, clip_right_reg});
        reject   = (x_s < left_s - w_s) || (x_s > right_s);
        cnt_half = w_sat[SIZE_W-1:1];

        excess_s = x_s + w_s - right_s;
        trim_r   = excess_s[10:1];
        if (excess_s > 13'sd0)
        begin
            cnt_r = (trim_r >= 10'(cnt_half)) ? '0 : cnt_half - trim_r[BYTE_CNT_W-1:0];
            ofs_r = hflip_in ? cnt_half - cnt_r : '0;
        end
        else
        begin
            cnt_r = cnt_half;
            ofs_r = '0;
        end

        lgap_s = left_s - x_s + 13'sd1;
        adj    = lgap_s[11:1];
        if (x_s < left_s)
        begin
            base_adj = display_base + ADDRESS_BITS'({adj, 1'b0});
            cnt_l    = (adj >= 11'(cnt_r)) ? '0 : cnt_r - adj[BYTE_CNT_W-1:0];
            ofs_l    = ofs_r[BYTE_OFS_W-1:0] + (hflip_in ? '0 : adj[BYTE_OFS_W-1:0]);
        end
        else
        begin
            base_adj = display_base;
            cnt_l    = cnt_r;
            ofs_l    = ofs_r[BYTE_OFS_W-1:0];
        end
    end

    // ---------------- row visibility and address ----------------
    always_comb
    begin
        row_live   = row_cnt_reg < height_reg;
        yrow       = flip_reg[1] ? height_reg - 6'd1 - row_cnt_reg : row_cnt_reg;
        ypix_s     = $signed({{2{top_reg[POS_W-1]}}, top_reg}) + $signed({7'b0, yrow});
        in_range   = (ypix_s >= $signed({3'b0, clip_top_reg}))
                  && (ypix_s <= $signed({3'b0, clip_bottom_reg}));
        row_offset = 17'(yrow) * 17'(stride_reg);
        row_addr   = first_addr_reg + ADDRESS_BITS'(row_offset);
    end

    // High nibble of byte b sits at nibble unit 2b+1 of the packed row
    assign nib_unit = {nib_idx_reg[NIB_IDX_W-1:1], ~nib_idx_reg[0]};
    assign cur_nib  = row_bits_reg[{nib_unit, 2'b00} +: 4];
    assign out_free = !out_valid_reg || !out_stall;
    assign push_mid = cmd.step && (cur_nib != 4'h0) && held_valid_reg;

    always_comb
    begin
        status.row_drawn  = row_live && !fully_reg && in_range && (vis_reg != '0);
        status.last_pos   = (remain_reg == '0);
        status.nib_nz     = (cur_nib != 4'h0);
        status.held_valid = held_valid_reg;
        status.out_free   = out_free;
    end

    // ---------------- configuration ----------------
    always_comb
    begin
        clip_left_next   = clip_left_reg;
        clip_right_next  = clip_right_reg;
        clip_top_next    = clip_top_reg;
        clip_bottom_next = clip_bottom_reg;
        stride_next      = stride_reg;
        if (cfg_write_enable)
        begin
            case (xsrb_cfg_reg_t'(cfg_index))
                CFG_CLIP_LEFT:   clip_left_next   = cfg_data[CLIP_W-1:0];
                CFG_CLIP_RIGHT:  clip_right_next  = cfg_data[CLIP_W-1:0];
                CFG_CLIP_TOP:    clip_top_next    = cfg_data[CLIP_W-1:0];
                CFG_CLIP_BOTTOM: clip_bottom_next = cfg_data[CLIP_W-1:0];
                CFG_LINE_STRIDE: stride_next      = cfg_data[STRIDE_W-1:0];
                default:         stride_next      = stride_reg;
            endcase
        end
    end

    // ---------------- sprite state ----------------
    always_comb
    begin
        first_addr_next = first_addr_reg;
        ofs_next        = ofs_reg;
        vis_next        = vis_reg;
        top_next        = top_reg;
        height_next     = height_reg;
        row_cnt_next    = row_cnt_reg;
        flip_next       = flip_reg;
        fully_next      = fully_reg;
        if (cmd.sprite_load)
        begin
            top_next     = pos_y;
            height_next  = h_sat;
            flip_next    = flip_bits;
            row_cnt_next = '0;
            fully_next   = reject;
            if (reject)
            begin
                first_addr_next = display_base;
                vis_next        = '0;
                ofs_next        = '0;
            end
            else
            begin
                first_addr_next = base_adj;
                vis_next        = cnt_l;
                ofs_next        = ofs_l;
            end
        end
        else if (cmd.row_count && row_live)
        begin
            row_cnt_next = row_cnt_reg + 6'd1;
        end
    end

    // ---------------- row walk and output ----------------
    always_comb
    begin
        row_bits_next   = row_bits_reg;
        cur_addr_next   = cur_addr_reg;
        nib_idx_next    = nib_idx_reg;
        remain_next     = remain_reg;
        held_valid_next = held_valid_reg;
        held_addr_next  = held_addr_reg;
        held_nib_next   = held_nib_reg;
        out_addr_next   = out_addr_reg;
        out_nib_next    = out_nib_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.row_load)
        begin
            row_bits_next   = {row_bytes_high, row_bytes_low};
            cur_addr_next   = row_addr;
            held_valid_next = 1'b0;
            remain_next     = {vis_reg[3:0], 1'b0} - 5'd1;
            if (flip_reg[0])
            begin
                nib_idx_next = {ofs_reg, 1'b0} + {vis_reg[3:0], 1'b0} - 5'd1;
            end
            else
            begin
                nib_idx_next = {ofs_reg, 1'b0};
            end
        end

        if (cmd.step)
        begin
            cur_addr_next = cur_addr_reg + 1'b1;
            remain_next   = remain_reg - 5'd1;
            nib_idx_next  = flip_reg[0] ? nib_idx_reg - 5'd1 : nib_idx_reg + 5'd1;
            if (cur_nib != 4'h0)
            begin
                held_valid_next = 1'b1;
                held_addr_next  = cur_addr_reg;
                held_nib_next   = cur_nib;
            end
        end

        // Pass the held transaction on: mid-row when displaced, last when flushed
        if (push_mid || cmd.flush)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = held_addr_reg;
            out_nib_next   = held_nib_reg;
            out_last_next  = cmd.flush;
        end
        if (cmd.flush)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= CLIP_LEFT_RST;
            clip_right_reg  <= CLIP_RIGHT_RST;
            clip_top_reg    <= CLIP_TOP_RST;
            clip_bottom_reg <= CLIP_BOTTOM_RST;
            stride_reg      <= STRIDE_RST;
            first_addr_reg  <= '0;
            ofs_reg         <= '0;
            vis_reg         <= '0;
            top_reg         <= '0;
            height_reg      <= '0;
            row_cnt_reg     <= '0;
            flip_reg        <= '0;
            fully_reg       <= 1'b1;
            nib_idx_reg     <= '0;
            remain_reg      <= '0;
            held_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            clip_left_reg   <= clip_left_next;
            clip_right_reg  <= clip_right_next;
            clip_top_reg    <= clip_top_next;
            clip_bottom_reg <= clip_bottom_next;
            stride_reg      <= stride_next;
            first_addr_reg  <= first_addr_next;
            ofs_reg         <= ofs_next;
            vis_reg         <= vis_next;
            top_reg         <= top_next;
            height_reg      <= height_next;
            row_cnt_reg     <= row_cnt_next;
            flip_reg        <= flip_next;
            fully_reg       <= fully_next;
            nib_idx_reg     <= nib_idx_next;
            remain_reg      <= remain_next;
            held_valid_reg  <= held_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_bits_reg  <= row_bits_next;
        cur_addr_reg  <= cur_addr_next;
        held_addr_reg <= held_addr_next;
        held_nib_reg  <= held_nib_next;
        out_addr_reg  <= out_addr_next;
        out_nib_reg   <= out_nib_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign write_address = out_addr_reg;
    assign xor_mask      = {out_nib_reg, 4'h0};
    assign last_of_row   = out_last_reg;

endmodule

@@ src/xor_sprite_row_blitter.sv @@
// XOR sprite row blitter: clips a 4bpp sprite and turns image rows into display XOR writes.
//
// Input channel (in_valid / in_stall): a start transaction (command 0) latches position,
// size, flips and display base and works out the horizontal clip in the accepting cycle.
// A row transaction (command 1) carries one packed image row of up to 16 bytes.
// Output channel (out_valid / out_stall): one transaction per nonzero nibble in view,
// giving the display byte address and the XOR mask; last_of_row marks the row's final one.
// Configuration: cfg_write_enable writes cfg_data into the register at cfg_index
// (clip left, right, top, bottom, line stride); write only while the block is idle.
// Timing: start transactions and rows that draw nothing are taken every cycle.
// A drawn row of N visible bytes closes the input until its walk and flush are done:
// the walk takes one nibble per cycle unless a stalled output holds it, then the last
// result is flushed through the single output register before a new row is taken.
// A result is held until the next nonzero nibble or the flush shows whether it is the
// last, and only then moves to the output register.
// A stalled output freezes the walk when a new result needs the slot.
// Reset restores the default clip window and stride and marks the sprite as rejected,
// so rows before a start command produce nothing.
module xor_sprite_row_blitter
    import xsrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [SIZE_W-1:0]        width_pixels,
    input  logic [SIZE_W-1:0]        height_rows,
    input  logic [1:0]               flip_bits,
    input  logic [ADDRESS_BITS-1:0]  display_base,
    input  logic [ROW_HALF_W-1:0]    row_bytes_low,
    input  logic [ROW_HALF_W-1:0]    row_bytes_high,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ADDRESS_BITS-1:0]  write_address,
    output logic [7:0]               xor_mask,
    output logic                     last_of_row
);

    xsrb_cmd_t    cmd;
    xsrb_status_t status;

    xsrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    xsrb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .width_pixels     (width_pixels),
        .height_rows      (height_rows),
        .flip_bits        (flip_bits),
        .display_base     (display_base),
        .row_bytes_low    (row_bytes_low),
        .row_bytes_high   (row_bytes_high),
        .out_stall        (out_stall),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .write_address    (write_address),
        .xor_mask         (xor_mask),
        .last_of_row      (last_of_row)
    );

endmodule

@@ src/xsrb_checker.sv @@
// Port-level checks for the sprite row blitter, bound to the top level.
`include "xor_sprite_row_blitter_defines.svh"

module xsrb_checker
    import xsrb_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    command,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [ADDRESS_BITS-1:0] write_address,
    input logic [7:0]              xor_mask,
    input logic                    last_of_row
);

    // A stalled result transaction stays put
    `XSRB_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(write_address) && $stable(xor_mask) && $stable(last_of_row), "stalled result changed")

    // Only nonzero nibbles go out, in the high half
    `XSRB_ASSERT_CLK(a_mask_shape, out_valid |-> xor_mask[3:0] == 4'h0 && xor_mask[7:4] != 4'h0, "bad xor mask")

    // A row is still being walked while one of its non-final results waits
    `XSRB_ASSERT_CLK(a_busy_mid_row, out_valid && !last_of_row |-> in_stall, "input open mid-row")

    // Input closes only after taking a row transaction
    `XSRB_ASSERT_CLK(a_stall_after_row, $rose(in_stall) |-> $past(in_valid) && $past(command) == CMD_ROW, "stall without row")

endmodule

bind xor_sprite_row_blitter xsrb_checker u_xsrb_checker (.*);

@@ tb/xsrb_blit_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels and the register port, predicts every XOR write and compares it.
module xsrb_blit_checker
    import xsrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     command,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [SIZE_W-1:0]        width_pixels,
    input  logic [SIZE_W-1:0]        height_rows,
    input  logic [1:0]               flip_bits,
    input  logic [ADDRESS_BITS-1:0]  display_base,
    input  logic [ROW_HALF_W-1:0]    row_bytes_low,
    input  logic [ROW_HALF_W-1:0]    row_bytes_high,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [ADDRESS_BITS-1:0]  write_address,
    input  logic [7:0]               xor_mask,
    input  logic                     last_of_row,
    output int                       mismatch_count,
    output int                       outstanding_writes,
    output int                       writes_checked,
    output int                       rows_drawn
);

    localparam int HFLIP_BIT     = 0;
    localparam int VFLIP_BIT     = 1;
    localparam int MAX_ROW_BYTES = 16;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] address;
        logic [7:0]              mask;
        logic                    last;
    } xor_write_t;

    logic [CLIP_W-1:0]       clip_left;
    logic [CLIP_W-1:0]       clip_right;
    logic [CLIP_W-1:0]       clip_top;
    logic [CLIP_W-1:0]       clip_bottom;
    logic [STRIDE_W-1:0]     line_stride;

    logic [ADDRESS_BITS-1:0] first_row_address;
    logic [BYTE_OFS_W-1:0]   image_byte_offset;
    logic [BYTE_CNT_W-1:0]   visible_byte_count;
    logic signed [POS_W-1:0] top_row;
    logic [SIZE_W-1:0]       sprite_height;
    logic [SIZE_W-1:0]       row_counter;
    logic [1:0]              flip_state;
    logic                    fully_clipped;

    xor_write_t              pending_xor_writes[$];
    xor_write_t              oldest;

    function automatic void queue_nibble(logic [ADDRESS_BITS-1:0] address, logic [3:0] nibble);
        // a blank pixel still takes its display byte but causes no write
        if (nibble != 4'h0)
            pending_xor_writes.push_back('{address, {nibble, 4'h0}, 1'b0});
    endfunction

    task automatic latch_sprite_clip();
        int x;
        int w;
        int h;
        int left;
        int right;
        int count;
        int offset;
        int adj;
        logic [ADDRESS_BITS-1:0] base;
        x      = int'(pos_x);
        w      = int'(width_pixels);
        h      = int'(height_rows);
        left   = int'(clip_left);
        right  = int'(clip_right);
        base   = display_base;
        offset = 0;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        top_row       = pos_y;
        sprite_height = SIZE_W'(h);
        flip_state    = flip_bits;
        row_counter   = '0;
        if (x < left - w || x > right)
        begin
            fully_clipped      = 1'b1;
            visible_byte_count = '0;
            image_byte_offset  = '0;
            first_row_address  = base;
            return;
        end
        fully_clipped = 1'b0;
        count = w / 2;
        if (x + w > right)
        begin
            count -= (x + w - right) / 2;
            if (count < 0)
                count = 0;
            // a mirrored sprite loses its right edge from the start of storage
            if (flip_state[HFLIP_BIT])
                offset += w / 2 - count;
        end
        if (x < left)
        begin
            adj = (left - x + 1) / 2;
            base = base + ADDRESS_BITS'(2 * adj);
            if (!flip_state[HFLIP_BIT])
                offset += adj;
            count -= adj;
            if (count < 0)
                count = 0;
        end
        first_row_address  = base;
        visible_byte_count = BYTE_CNT_W'(count);
        image_byte_offset  = BYTE_OFS_W'(offset);
    endtask

    task automatic expand_image_row();
        logic [ROW_W-1:0]        row;
        logic [BYTE_OFS_W-1:0]   k;
        logic [7:0]              b;
        logic [ADDRESS_BITS-1:0] a;
        int r;
        int yrow;
        int ypix;
        int cnt;
        int first_new;
        if (row_counter >= sprite_height)
            return;
        r = int'(row_counter);
        row_counter = row_counter + 1'b1;
        if (fully_clipped)
            return;
        yrow = flip_state[VFLIP_BIT] ? int'(sprite_height) - 1 - r : r;
        ypix = int'(top_row) + yrow;
        if (ypix < int'(clip_top) || ypix > int'(clip_bottom))
            return;
        row = {row_bytes_high, row_bytes_low};
        cnt = (visible_byte_count > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(visible_byte_count);
        first_new = pending_xor_writes.size();
        for (int i = 0; i < cnt; i++)
        begin
            a = first_row_address + ADDRESS_BITS'(yrow * int'(line_stride))
                + ADDRESS_BITS'(2 * i);
            if (flip_state[HFLIP_BIT])
            begin
                // walk storage backwards, low nibble first
                k = BYTE_OFS_W'(int'(image_byte_offset) + cnt - 1 - i);
                b = row[8 * k +: 8];
                queue_nibble(a, b[3:0]);
                queue_nibble(a + 1'b1, b[7:4]);
            end
            else
            begin
                k = BYTE_OFS_W'(int'(image_byte_offset) + i);
                b = row[8 * k +: 8];
                queue_nibble(a, b[7:4]);
                queue_nibble(a + 1'b1, b[3:0]);
            end
        end
        if (pending_xor_writes.size() > first_new)
        begin
            pending_xor_writes[pending_xor_writes.size() - 1].last = 1'b1;
            rows_drawn++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left          = CLIP_LEFT_RST;
            clip_right         = CLIP_RIGHT_RST;
            clip_top           = CLIP_TOP_RST;
            clip_bottom        = CLIP_BOTTOM_RST;
            line_stride        = STRIDE_RST;
            first_row_address  = '0;
            image_byte_offset  = '0;
            visible_byte_count = '0;
            top_row            = '0;
            sprite_height      = '0;
            row_counter        = '0;
            flip_state         = '0;
            fully_clipped      = 1'b1;
            mismatch_count     = 0;
            writes_checked     = 0;
            rows_drawn         = 0;
            pending_xor_writes.delete();
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_CLIP_LEFT:   clip_left   = cfg_data[CLIP_W-1:0];
                    CFG_CLIP_RIGHT:  clip_right  = cfg_data[CLIP_W-1:0];
                    CFG_CLIP_TOP:    clip_top    = cfg_data[CLIP_W-1:0];
                    CFG_CLIP_BOTTOM: clip_bottom = cfg_data[CLIP_W-1:0];
                    CFG_LINE_STRIDE: line_stride = cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_xor_writes.size() == 0)
                begin
                    $error("unexpected XOR write: address %h, mask %h, last %b",
                           write_address, xor_mask, last_of_row);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_xor_writes.pop_front();
                    writes_checked++;
                    if (write_address !== oldest.address)
                    begin
                        $error("write_address: expected %h, got %h",
                               oldest.address, write_address);
                        mismatch_count++;
                    end
                    if (xor_mask !== oldest.mask)
                    begin
                        $error("xor_mask: expected %h, got %h", oldest.mask, xor_mask);
                        mismatch_count++;
                    end
                    if (last_of_row !== oldest.last)
                    begin
                        $error("last_of_row: expected %b, got %b", oldest.last, last_of_row);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_START)
                    latch_sprite_clip();
                else
                    expand_image_row();
            end
        end
        outstanding_writes = pending_xor_writes.size();
    end

endmodule

@@ tb/tb_xor_sprite_row_blitter.sv @@
`timescale 1ns / 100ps
// Testbench top for the sprite row blitter: clock, reset, stimulus, idling and verdict.
module tb_xor_sprite_row_blitter;
    import xsrb_pkg::*;

    localparam int SPRITE_MAX_W = 32;
    localparam int SPRITE_MAX_H = 32;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int LONG_HOLD    = 300;

    localparam int FLIP_NONE = 0;
    localparam int FLIP_H    = 1;
    localparam int FLIP_V    = 2;
    localparam int FLIP_HV   = 3;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write_enable;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        width_pixels;
    logic [SIZE_W-1:0]        height_rows;
    logic [1:0]               flip_bits;
    logic [ADDRESS_BITS-1:0]  display_base;
    logic [ROW_HALF_W-1:0]    row_bytes_low;
    logic [ROW_HALF_W-1:0]    row_bytes_high;
    logic                     out_valid;
    logic                     out_stall;
    logic [ADDRESS_BITS-1:0]  write_address;
    logic [7:0]               xor_mask;
    logic                     last_of_row;

    int mismatch_count;
    int outstanding_writes;
    int writes_checked;
    int rows_drawn;

    int cycle_count      = 0;
    int hold_off_cycles  = 0;
    int total_sent       = 0;
    int phase_items      = 0;
    int settings_applied = 1;
    bit sender_eager     = 1'b0;
    int cur_left         = CLIP_LEFT_RST;
    int cur_right        = CLIP_RIGHT_RST;
    int cur_top          = CLIP_TOP_RST;
    int cur_bottom       = CLIP_BOTTOM_RST;

    xor_sprite_row_blitter #(
        .MAX_WIDTH  (SPRITE_MAX_W),
        .MAX_HEIGHT (SPRITE_MAX_H)
    ) dut (.*);

    xsrb_blit_checker #(
        .MAX_WIDTH  (SPRITE_MAX_W),
        .MAX_HEIGHT (SPRITE_MAX_H)
    ) u_checker (.*);

    always #1 clk = ~clk;

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_pos(int v);
        return (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
    endfunction

    // density: chance in sixteen that a nibble is nonzero
    function automatic logic [ROW_W-1:0] image_row(int density);
        logic [ROW_W-1:0] row;
        row = '0;
        for (int n = 0; n < ROW_W / 4; n++)
            if (pick_between(1, 16) <= density)
                row[4 * n +: 4] = 4'(pick_between(1, 15));
        return row;
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick < 4)
            return image_row(pick_between(1, 15));
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic sender_gap();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_eager || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = pick_between(1, 3);
        else
            gap = pick_between(8, 30);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_start(int x, int y, int w, int h, int f, logic [ADDRESS_BITS-1:0] base);
        @(negedge clk);
        in_valid       = 1'b1;
        command        = CMD_START;
        pos_x          = POS_W'(x);
        pos_y          = POS_W'(y);
        width_pixels   = SIZE_W'(w);
        height_rows    = SIZE_W'(h);
        flip_bits      = 2'(f);
        display_base   = base;
        row_bytes_low  = {$urandom, $urandom};
        row_bytes_high = {$urandom, $urandom};
        do @(posedge clk); while (in_stall);
        total_sent++;
        sender_gap();
    endtask

    task automatic send_row(logic [ROW_W-1:0] row);
        @(negedge clk);
        in_valid       = 1'b1;
        command        = CMD_ROW;
        pos_x          = POS_W'($urandom);
        pos_y          = POS_W'($urandom);
        width_pixels   = SIZE_W'($urandom);
        height_rows    = SIZE_W'($urandom);
        flip_bits      = 2'($urandom);
        display_base   = ADDRESS_BITS'($urandom);
        row_bytes_low  = row[ROW_HALF_W-1:0];
        row_bytes_high = row[ROW_W-1:ROW_HALF_W];
        do @(posedge clk); while (in_stall);
        total_sent++;
        sender_gap();
    endtask

    // Hold the sender until every predicted write has drained, then let a silent row finish.
    task automatic settle_idle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (outstanding_writes == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_index        = index;
        cfg_data         = data;
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    task automatic configure(int l, int r, int t, int b, int s);
        settle_idle();
        // the spare top bit of the data must be dropped by the clip registers
        write_reg(CFG_CLIP_LEFT,   {1'($urandom_range(0, 1)), CLIP_W'(l)});
        write_reg(CFG_CLIP_RIGHT,  {1'($urandom_range(0, 1)), CLIP_W'(r)});
        write_reg(CFG_CLIP_TOP,    {1'($urandom_range(0, 1)), CLIP_W'(t)});
        write_reg(CFG_CLIP_BOTTOM, {1'($urandom_range(0, 1)), CLIP_W'(b)});
        write_reg(CFG_LINE_STRIDE, STRIDE_W'(s));
        for (int k = int'(CFG_LINE_STRIDE) + 1; k < (1 << CFG_INDEX_W); k++)
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        cur_left   = l;
        cur_right  = r;
        cur_top    = t;
        cur_bottom = b;
        settings_applied++;
    endtask

    task automatic random_sprite();
        int x;
        int y;
        int w;
        int h;
        int eff_h;
        int rows_planned;
        int pick;
        int xlo;
        int xhi;
        int ylo;
        int yhi;
        sender_eager = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 15) == 0)
            send_row(random_row());
        xlo = ((cur_left < cur_right) ? cur_left : cur_right) - 40;
        xhi = ((cur_left > cur_right) ? cur_left : cur_right) + 8;
        ylo = ((cur_top < cur_bottom) ? cur_top : cur_bottom) - 10;
        yhi = ((cur_top > cur_bottom) ? cur_top : cur_bottom) + 2;

        pick = $urandom_range(0, 9);
        if (pick < 6)
            w = 2 * pick_between(0, 16);
        else if (pick < 8)
            w = 2 * pick_between(0, 15) + 1;
        else if (pick < 9)
            w = pick_between(33, 63);
        else
            w = SPRITE_MAX_W;

        pick = $urandom_range(0, 9);
        if (pick < 7)
            x = pick_between(xlo, xhi);
        else if (pick == 7)
            x = cur_left - w + pick_between(-2, 2);
        else if (pick == 8)
            x = cur_right - w + pick_between(-2, 4);
        else
            x = pick_between(-1024, 1023);
        x = clamp_pos(x);

        y = ($urandom_range(0, 9) < 8) ? clamp_pos(pick_between(ylo, yhi))
                                       : pick_between(-1024, 1023);

        pick = $urandom_range(0, 9);
        if (pick < 7)
            h = pick_between(1, 6);
        else if (pick == 7)
            h = 0;
        else if (pick == 8)
            h = pick_between(7, 32);
        else
            h = pick_between(33, 63);
        eff_h = (h > SPRITE_MAX_H) ? SPRITE_MAX_H : h;

        // mostly complete sprites; some abandoned early, some overrun
        pick = $urandom_range(0, 9);
        if (pick < 8)
            rows_planned = eff_h;
        else if (pick == 8)
            rows_planned = (eff_h > 0) ? pick_between(0, eff_h - 1) : 0;
        else
            rows_planned = eff_h + pick_between(1, 3);

        send_start(x, y, w, h, $urandom_range(0, 3), ADDRESS_BITS'($urandom));
        phase_items++;
        for (int i = 0; i < rows_planned; i++)
        begin
            send_row(random_row());
            if (i < eff_h)
                phase_items++;
        end
    endtask

    task automatic run_phase(int quota);
        phase_items = 0;
        while (phase_items < quota)
            random_sprite();
    endtask

    // Output side: random stall bursts, free stretches, and a long hold when asked.
    initial
    begin
        int pick;
        int run_len;
        logic run_stall;
        out_stall = 1'b0;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_off_cycles > 0)
            begin
                run_len         = hold_off_cycles;
                run_stall       = 1'b1;
                hold_off_cycles = 0;
            end
            else if (pick < 45)
            begin
                run_len   = pick_between(1, 8);
                run_stall = 1'b0;
            end
            else if (pick < 55)
            begin
                run_len   = pick_between(20, 40);
                run_stall = 1'b0;
            end
            else if (pick < 92)
            begin
                run_len   = pick_between(1, 3);
                run_stall = 1'b1;
            end
            else
            begin
                run_len   = pick_between(8, 30);
                run_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = run_stall;
            repeat (run_len - 1) @(negedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int l;
        int t;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = CFG_CLIP_LEFT;
        cfg_data         = '0;
        in_valid         = 1'b0;
        command          = CMD_ROW;
        pos_x            = '0;
        pos_y            = '0;
        width_pixels     = '0;
        height_rows      = '0;
        flip_bits        = '0;
        display_base     = '0;
        row_bytes_low    = '0;
        row_bytes_high   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed sprites under the reset clip window
        send_row({ROW_W{1'b1}});
        send_start(0, 0, 32, 2, FLIP_NONE, 24'hFFFFF0);
        send_row({ROW_W{1'b1}});
        send_row(random_row());
        send_start(-5, 0, 32, 2, FLIP_HV, 24'h001000);
        send_row(image_row(12));
        send_row({$urandom, $urandom, $urandom, $urandom});
        send_start(310, 239, 32, 1, FLIP_H, 24'h020000);
        send_row({$urandom, $urandom, $urandom, $urandom});
        send_start(-1024, 10, 0, 4, FLIP_NONE, 24'h000000);
        send_row({ROW_W{1'b1}});
        send_start(1023, 1023, 63, 63, FLIP_V, 24'hFFFFFF);
        send_row({ROW_W{1'b1}});
        send_start(100, -3, 63, 63, FLIP_NONE, ADDRESS_BITS'($urandom));
        repeat (4) send_row(image_row(16));
        send_start(10, 5, 7, 1, FLIP_V, ADDRESS_BITS'($urandom));
        send_row(image_row(16));
        send_start(20, 20, 8, 1, FLIP_NONE, ADDRESS_BITS'($urandom));
        send_row('0);
        send_row(image_row(16));

        // long output hold while full rows keep arriving
        settle_idle();
        sender_eager    = 1'b1;
        hold_off_cycles = LONG_HOLD;
        send_start(0, 0, 32, 8, FLIP_NONE, 24'h004000);
        repeat (8) send_row(image_row(16));
        sender_eager = 1'b0;

        configure(0, 1023, 0, 1023, 1024);
        run_phase(70);
        configure(1023, 1023, 1023, 1023, 1);
        run_phase(40);
        l = $urandom_range(0, 400);
        t = $urandom_range(0, 300);
        configure(l, l + pick_between(8, 500), t, t + pick_between(4, 300),
                  $urandom_range(1, 1024));
        run_phase(70);
        configure(16, 200, 8, 120, 0);
        run_phase(70);
        configure(5, 90, 60, 30, 2047);
        run_phase(20);
        l = $urandom_range(0, 600);
        t = $urandom_range(0, 600);
        configure(l, l + pick_between(8, 400), t, t + pick_between(4, 400),
                  $urandom_range(1, 1024));
        run_phase(70);
        configure(CLIP_LEFT_RST, CLIP_RIGHT_RST, CLIP_TOP_RST, CLIP_BOTTOM_RST, STRIDE_RST);
        run_phase(70);

        settle_idle();
        $display("Sent %0d transactions under %0d clip settings; checked %0d XOR writes from %0d rows.",
                 total_sent, settings_applied, writes_checked, rows_drawn);
        $display("Covered rejects, edge trims, both flips, oversized and odd sprites, stride extremes.");
        if (mismatch_count == 0 && outstanding_writes == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
